>>> sv/hrbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_pkg
// Types, codes and constant text tables of the HTTP request byte parser.
// ----------------------------------------------------------------------------
package hrbp_pkg;

  localparam int unsigned HEADER_LIMIT = 4096;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_LIMIT + 1);
  localparam logic [19:0] BODY_LIMIT   = 20'd1048575;
  localparam int unsigned MAX_RES      = 3;
  localparam int unsigned HDR_COUNT    = 7;

  // parse states, ordered: header states up to S_BLANK, body states after
  typedef enum logic [4:0] {
    S_METHOD, S_PRE_PATH, S_PATH, S_QSTART, S_QNAME, S_QVSTART, S_QVALUE,
    S_PRE_VER, S_VER, S_VER_TAIL, S_LINE, S_HNAME, S_HNAME_TAIL, S_PRE_VAL,
    S_HVAL, S_HVAL_TAIL, S_BLANK, S_BODY_RAW, S_BODY_FORM, S_DONE
  } state_t;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // parts
  localparam logic [3:0] PART_METHOD  = 4'd0;
  localparam logic [3:0] PART_PATH    = 4'd1;
  localparam logic [3:0] PART_QNAME   = 4'd2;
  localparam logic [3:0] PART_QVALUE  = 4'd3;
  localparam logic [3:0] PART_VERSION = 4'd4;
  localparam logic [3:0] PART_HNAME   = 4'd5;
  localparam logic [3:0] PART_HVALUE  = 4'd6;
  localparam logic [3:0] PART_BODY    = 4'd7;
  localparam logic [3:0] PART_FNAME   = 4'd8;
  localparam logic [3:0] PART_FVALUE  = 4'd9;

  // methods
  localparam logic [3:0] M_NONE    = 4'd0;
  localparam logic [3:0] M_GET     = 4'd1;
  localparam logic [3:0] M_PUT     = 4'd2;
  localparam logic [3:0] M_POST    = 4'd3;
  localparam logic [3:0] M_HEAD    = 4'd4;
  localparam logic [3:0] M_PATCH   = 4'd5;
  localparam logic [3:0] M_DELETE  = 4'd6;
  localparam logic [3:0] M_TRACE   = 4'd7;
  localparam logic [3:0] M_OPTIONS = 4'd8;
  localparam logic [3:0] M_CONNECT = 4'd9;

  // header kinds
  localparam logic [2:0] HK_OTHER  = 3'd0;
  localparam logic [2:0] HK_TYPE   = 3'd6;
  localparam logic [2:0] HK_LENGTH = 3'd7;

  // error codes
  localparam logic [1:0] ERR_METHOD   = 2'd0;
  localparam logic [1:0] ERR_NO_LF    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // number parser phases and radix codes
  localparam logic [2:0] NP_LEAD   = 3'd0;
  localparam logic [2:0] NP_FIRST  = 3'd1;
  localparam logic [2:0] NP_ZERO   = 3'd2;
  localparam logic [2:0] NP_HEX1   = 3'd3;
  localparam logic [2:0] NP_DIGITS = 3'd5;
  localparam logic [2:0] NP_STOP   = 3'd6;
  localparam logic [1:0] RDX_NONE  = 2'd0;
  localparam logic [1:0] RDX_OCT   = 2'd1;
  localparam logic [1:0] RDX_DEC   = 2'd2;
  localparam logic [1:0] RDX_HEX   = 2'd3;

  // byte codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam int unsigned TXT_W = 8 * 34;
  localparam logic [5:0]  FORM_LEN = 6'd33;
  localparam logic [TXT_W-1:0] FORM_TXT = "application/x-www-form-urlencoded";

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  part;
    logic [7:0]  out_byte;
    logic [3:0]  method_code;
    logic [2:0]  header_kind;
    logic [19:0] body_length;
    logic        form_encoded;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic hex_ok(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (c >= "0" && c <= "9") || (l >= "a" && l <= "f");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (c <= "9") ? 4'(c - "0") : 4'(l - "a" + 8'd10);
  endfunction

  // character at pos of a right-justified text of len characters
  function automatic logic [7:0] str_at(logic [TXT_W-1:0] s, logic [5:0] len,
                                        logic [5:0] pos);
    logic [8:0] sh;
    sh = {3'b000, len - 6'd1 - pos} << 3;
    return (pos < len) ? s[sh +: 8] : 8'd0;
  endfunction

  function automatic logic [2:0] method_len(logic [3:0] m);
    case (m)
      M_GET, M_PUT:           return 3'd3;
      M_POST, M_HEAD:         return 3'd4;
      M_PATCH, M_TRACE:       return 3'd5;
      M_DELETE:               return 3'd6;
      M_OPTIONS, M_CONNECT:   return 3'd7;
      default:                return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] method_char(logic [3:0] m, logic [5:0] i);
    logic [5:0] n;
    n = {3'b000, method_len(m)};
    case (m)
      M_GET:     return str_at(TXT_W'("get"), n, i);
      M_PUT:     return str_at(TXT_W'("put"), n, i);
      M_POST:    return str_at(TXT_W'("post"), n, i);
      M_HEAD:    return str_at(TXT_W'("head"), n, i);
      M_PATCH:   return str_at(TXT_W'("patch"), n, i);
      M_DELETE:  return str_at(TXT_W'("delete"), n, i);
      M_TRACE:   return str_at(TXT_W'("trace"), n, i);
      M_OPTIONS: return str_at(TXT_W'("options"), n, i);
      M_CONNECT: return str_at(TXT_W'("connect"), n, i);
      default:   return 8'd0;
    endcase
  endfunction

  function automatic logic [4:0] hdr_len(logic [2:0] k);
    case (k)
      3'd0:    return 5'd4;
      3'd1:    return 5'd6;
      3'd2:    return 5'd17;
      3'd3:    return 5'd22;
      3'd4:    return 5'd21;
      3'd5:    return 5'd12;
      3'd6:    return 5'd14;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] hdr_char(logic [2:0] k, logic [4:0] pos);
    logic [5:0] n;
    logic [5:0] p;
    n = {1'b0, hdr_len(k)};
    p = {1'b0, pos};
    case (k)
      3'd0:    return str_at(TXT_W'("host"), n, p);
      3'd1:    return str_at(TXT_W'("origin"), n, p);
      3'd2:    return str_at(TXT_W'("sec-websocket-key"), n, p);
      3'd3:    return str_at(TXT_W'("sec-websocket-protocol"), n, p);
      3'd4:    return str_at(TXT_W'("sec-websocket-version"), n, p);
      3'd5:    return str_at(TXT_W'("content-type"), n, p);
      3'd6:    return str_at(TXT_W'("content-length"), n, p);
      default: return 8'd0;
    endcase
  endfunction

endpackage

>>> sv/hrbp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_parser
// Parse state of the request and the per-byte step that yields up to three
// results; state advances on every accepted request.
// ----------------------------------------------------------------------------
module hrbp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    packet_start,
  output hrbp_pkg::result_t [2:0] res,
  output logic [1:0]              res_cnt
);

  hrbp_pkg::state_t ps_r, ps_nxt;
  logic [1:0]  esc_ph_r, esc_ph_nxt;
  logic [7:0]  esc_val_r, esc_val_nxt;
  logic [hrbp_pkg::HDR_CNT_W-1:0] hdr_r, hdr_nxt;
  logic [3:0]  ms_r, ms_nxt;
  logic [6:0]  cand_r, cand_nxt;
  logic [4:0]  npos_r, npos_nxt;
  logic [6:0]  tm_r, tm_nxt;
  logic [19:0] len_r, len_nxt;
  logic [1:0]  rdx_r, rdx_nxt;
  logic [19:0] brx_r, brx_nxt;
  logic        drop_r, drop_nxt;
  logic [2:0]  nph_r, nph_nxt;
  logic        nneg_r, nneg_nxt;
  logic [19:0] nval_r, nval_nxt;
  logic        tseen_r, tseen_nxt;
  logic        form_r, form_nxt;
  logic        fval_r, fval_nxt;

  function automatic hrbp_pkg::result_t mk(logic [1:0] kind, logic [3:0] part,
      logic [7:0] b, logic [2:0] hk, logic [1:0] err, hrbp_pkg::state_t ps,
      logic [3:0] ms, logic [19:0] len, logic f);
    hrbp_pkg::result_t r;
    r.kind         = kind;
    r.part         = part;
    r.out_byte     = b;
    r.method_code  = (ps != hrbp_pkg::S_METHOD) ? ms : hrbp_pkg::M_NONE;
    r.header_kind  = hk;
    r.body_length  = len;
    r.form_encoded = f;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

  hrbp_pkg::result_t [2:0] res_v;
  logic [1:0]  n_v;
  logic [7:0]  c, lc;
  logic        go, bad, split, more, nd_ok;
  logic [3:0]  m, nd;
  logic [2:0]  hk;
  logic [5:0]  tpos;
  logic        tbad;
  logic [24:0] prod;

  // Step the parse for one byte
  always_comb begin
    ps_nxt = ps_r;  esc_ph_nxt = esc_ph_r;  esc_val_nxt = esc_val_r;
    hdr_nxt = hdr_r;  ms_nxt = ms_r;  cand_nxt = cand_r;  npos_nxt = npos_r;
    tm_nxt = tm_r;  len_nxt = len_r;  rdx_nxt = rdx_r;  brx_nxt = brx_r;
    drop_nxt = drop_r;  nph_nxt = nph_r;  nneg_nxt = nneg_r;  nval_nxt = nval_r;
    tseen_nxt = tseen_r;  form_nxt = form_r;  fval_nxt = fval_r;
    res_v = '0;  n_v = 2'd0;  go = 1'b0;  bad = 1'b0;  split = 1'b0;
    more = 1'b0;  nd_ok = 1'b0;  m = 4'd0;  nd = 4'd0;  hk = 3'd0;
    tpos = 6'd0;  tbad = 1'b0;  prod = '0;
    c = 8'd0;  lc = 8'd0;

    // Restart on a new packet
    if (packet_start) begin
      drop_nxt = 1'b0;
      if (ps_r == hrbp_pkg::S_DONE) begin
        ps_nxt = hrbp_pkg::S_METHOD;  esc_ph_nxt = 2'd0;  esc_val_nxt = 8'd0;
        hdr_nxt = '0;  ms_nxt = 4'd0;  cand_nxt = 7'h7f;  npos_nxt = 5'd0;
        tm_nxt = 7'd0;  len_nxt = 20'd0;  rdx_nxt = hrbp_pkg::RDX_NONE;
        brx_nxt = 20'd0;  nph_nxt = hrbp_pkg::NP_LEAD;  nneg_nxt = 1'b0;
        nval_nxt = 20'd0;  tseen_nxt = 1'b0;  form_nxt = 1'b0;  fval_nxt = 1'b0;
      end
    end

    if (!drop_nxt && ps_nxt != hrbp_pkg::S_DONE) begin
      if (ps_nxt <= hrbp_pkg::S_BLANK && hdr_nxt >= hrbp_pkg::HDR_CNT_W'(hrbp_pkg::HEADER_LIMIT)) begin
        res_v[n_v] = mk(hrbp_pkg::KIND_ERROR, 4'd0, 8'd0, 3'd0, hrbp_pkg::ERR_OVERFLOW,
                        ps_nxt, ms_nxt, len_nxt, form_nxt);
        n_v = n_v + 2'd1;
        drop_nxt = 1'b1;
      end else begin
        // Percent-decode, and map plus to space, outside a raw body
        if (ps_nxt == hrbp_pkg::S_BODY_RAW) begin
          esc_val_nxt = data_byte;  go = 1'b1;
        end else if (esc_ph_nxt == 2'd0) begin
          if (data_byte == hrbp_pkg::CH_PCT) begin
            esc_ph_nxt = 2'd1;  esc_val_nxt = 8'd0;
          end else begin
            esc_val_nxt = (data_byte == hrbp_pkg::CH_PLUS) ? hrbp_pkg::CH_SP : data_byte;
            go = 1'b1;
          end
        end else if (esc_ph_nxt == 2'd1) begin
          if (hrbp_pkg::hex_ok(data_byte)) begin
            esc_ph_nxt = 2'd2;  esc_val_nxt = {hrbp_pkg::hex_val(data_byte), 4'd0};
          end
        end else begin
          if (hrbp_pkg::hex_ok(data_byte)) begin
            esc_ph_nxt = 2'd0;
            esc_val_nxt = esc_val_nxt + {4'd0, hrbp_pkg::hex_val(data_byte)};
            go = 1'b1;
          end
          if (ps_nxt == hrbp_pkg::S_BODY_FORM)
            len_nxt = (len_nxt >= 20'd2) ? len_nxt - 20'd2 : 20'd0;
        end

        c  = esc_val_nxt;
        lc = hrbp_pkg::to_lower(c);

        if (go) begin
          if (ps_nxt == hrbp_pkg::S_METHOD) begin
            // Match the method letter by letter
            if (npos_nxt == 5'd0) begin
              case (lc)
                "g":     m = hrbp_pkg::M_GET;
                "p":     m = hrbp_pkg::M_PUT;
                "h":     m = hrbp_pkg::M_HEAD;
                "d":     m = hrbp_pkg::M_DELETE;
                "t":     m = hrbp_pkg::M_TRACE;
                "o":     m = hrbp_pkg::M_OPTIONS;
                "c":     m = hrbp_pkg::M_CONNECT;
                default: m = hrbp_pkg::M_NONE;
              endcase
              if (m == hrbp_pkg::M_NONE) bad = 1'b1;
              else ms_nxt = m;
            end else if (ms_nxt == hrbp_pkg::M_PUT && npos_nxt == 5'd1) begin
              case (lc)
                "o":     m = hrbp_pkg::M_POST;
                "u":     m = hrbp_pkg::M_PUT;
                "a":     m = hrbp_pkg::M_PATCH;
                default: m = hrbp_pkg::M_NONE;
              endcase
              if (m == hrbp_pkg::M_NONE) bad = 1'b1;
              else ms_nxt = m;
            end else begin
              if (ms_nxt == hrbp_pkg::M_NONE || ms_nxt > hrbp_pkg::M_CONNECT ||
                  npos_nxt >= {2'd0, hrbp_pkg::method_len(ms_nxt)} ||
                  lc != hrbp_pkg::method_char(ms_nxt, {1'b0, npos_nxt}))
                bad = 1'b1;
            end
            if (bad) begin
              res_v[n_v] = mk(hrbp_pkg::KIND_ERROR, 4'd0, 8'd0, 3'd0, hrbp_pkg::ERR_METHOD,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
              drop_nxt = 1'b1;
            end else begin
              hdr_nxt  = hdr_nxt + 1'b1;
              npos_nxt = npos_nxt + 5'd1;
              res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_METHOD, c, 3'd0, 2'd0,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
              if (npos_nxt >= {2'd0, hrbp_pkg::method_len(ms_nxt)}) begin
                ps_nxt = hrbp_pkg::S_PRE_PATH;
                npos_nxt = 5'd0;
                res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_METHOD, 8'd0, 3'd0, 2'd0,
                                ps_nxt, ms_nxt, len_nxt, form_nxt);
                n_v = n_v + 2'd1;
              end
            end
          end else if (ps_nxt >= hrbp_pkg::S_BODY_RAW) begin
            // Body bytes, split into form fields for a POST of form type or no type
            split = (ms_nxt == hrbp_pkg::M_POST) && (!tseen_nxt || form_nxt);
            brx_nxt = brx_nxt + 20'd1;
            if (!split) begin
              res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_BODY, c, 3'd0, 2'd0,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
            end else if (!fval_nxt && c == hrbp_pkg::CH_EQ) begin
              res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_FNAME, 8'd0, 3'd0, 2'd0,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
              fval_nxt = 1'b1;
            end else if (fval_nxt && c == hrbp_pkg::CH_AMP) begin
              res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_FVALUE, 8'd0, 3'd0, 2'd0,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
              fval_nxt = 1'b0;
            end else begin
              res_v[n_v] = mk(hrbp_pkg::KIND_DATA,
                              fval_nxt ? hrbp_pkg::PART_FVALUE : hrbp_pkg::PART_FNAME,
                              c, 3'd0, 2'd0, ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
            end
            if (brx_nxt >= len_nxt) begin
              res_v[n_v] = mk(hrbp_pkg::KIND_END,
                              !split ? hrbp_pkg::PART_BODY :
                              (fval_nxt ? hrbp_pkg::PART_FVALUE : hrbp_pkg::PART_FNAME),
                              8'd0, 3'd0, 2'd0, ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
              ps_nxt = hrbp_pkg::S_DONE;
              res_v[n_v] = mk(hrbp_pkg::KIND_DONE, 4'd0, 8'd0, 3'd0, 2'd0,
                              ps_nxt, ms_nxt, len_nxt, form_nxt);
              n_v = n_v + 2'd1;
            end
          end else begin
            hdr_nxt = hdr_nxt + 1'b1;
            case (ps_nxt)
              hrbp_pkg::S_PRE_PATH: begin
                if (c != hrbp_pkg::CH_SP) begin
                  ps_nxt = hrbp_pkg::S_PATH;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_PATH, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end
              end
              hrbp_pkg::S_PATH: begin
                if (c == hrbp_pkg::CH_SP || c == hrbp_pkg::CH_QUEST) begin
                  ps_nxt = (c == hrbp_pkg::CH_SP) ? hrbp_pkg::S_PRE_VER : hrbp_pkg::S_QSTART;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_PATH, 8'd0, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end else begin
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_PATH, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end
                n_v = n_v + 2'd1;
              end
              hrbp_pkg::S_QSTART: begin
                if (c == hrbp_pkg::CH_SP) ps_nxt = hrbp_pkg::S_PRE_VER;
                else begin
                  ps_nxt = hrbp_pkg::S_QNAME;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_QNAME, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end
              end
              hrbp_pkg::S_QNAME: begin
                if (c == hrbp_pkg::CH_EQ) begin
                  ps_nxt = hrbp_pkg::S_QVSTART;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_QNAME, 8'd0, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end else begin
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_QNAME, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end
                n_v = n_v + 2'd1;
              end
              hrbp_pkg::S_QVSTART, hrbp_pkg::S_QVALUE: begin
                if (c == hrbp_pkg::CH_AMP || c == hrbp_pkg::CH_SP) begin
                  ps_nxt = (c == hrbp_pkg::CH_AMP) ? hrbp_pkg::S_QSTART : hrbp_pkg::S_PRE_VER;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_QVALUE, 8'd0, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end else begin
                  ps_nxt = hrbp_pkg::S_QVALUE;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_QVALUE, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end
                n_v = n_v + 2'd1;
              end
              hrbp_pkg::S_PRE_VER: begin
                if (c != hrbp_pkg::CH_SP) begin
                  ps_nxt = hrbp_pkg::S_VER;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_VERSION, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end
              end
              hrbp_pkg::S_VER: begin
                if (c == hrbp_pkg::CH_LF || c == hrbp_pkg::CH_SP || c == hrbp_pkg::CH_CR) begin
                  ps_nxt = (c == hrbp_pkg::CH_LF) ? hrbp_pkg::S_LINE : hrbp_pkg::S_VER_TAIL;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_VERSION, 8'd0, 3'd0,
                                  2'd0, ps_nxt, ms_nxt, len_nxt, form_nxt);
                end else begin
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_VERSION, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                end
                n_v = n_v + 2'd1;
              end
              hrbp_pkg::S_VER_TAIL, hrbp_pkg::S_HVAL_TAIL: begin
                if (c == hrbp_pkg::CH_LF) ps_nxt = hrbp_pkg::S_LINE;
              end
              hrbp_pkg::S_LINE, hrbp_pkg::S_HNAME: begin
                if (ps_nxt == hrbp_pkg::S_LINE && c == hrbp_pkg::CH_CR) begin
                  ps_nxt = hrbp_pkg::S_BLANK;
                end else if (ps_nxt == hrbp_pkg::S_HNAME &&
                             (c == hrbp_pkg::CH_SP || c == hrbp_pkg::CH_COLON)) begin
                  ps_nxt = (c == hrbp_pkg::CH_SP) ? hrbp_pkg::S_HNAME_TAIL : hrbp_pkg::S_PRE_VAL;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_HNAME, 8'd0, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end else begin
                  // Start a header line, then narrow the name candidates
                  if (ps_nxt == hrbp_pkg::S_LINE) begin
                    cand_nxt = 7'h7f;  npos_nxt = 5'd0;  tm_nxt = 7'd0;
                    nph_nxt = hrbp_pkg::NP_LEAD;  nneg_nxt = 1'b0;  nval_nxt = 20'd0;
                    rdx_nxt = hrbp_pkg::RDX_NONE;
                  end
                  for (int k = 0; k < hrbp_pkg::HDR_COUNT; k++) begin
                    if (cand_nxt[k] && (npos_nxt >= hrbp_pkg::hdr_len(3'(k)) ||
                        lc != hrbp_pkg::hdr_char(3'(k), npos_nxt)))
                      cand_nxt[k] = 1'b0;
                  end
                  if (npos_nxt != 5'd31) npos_nxt = npos_nxt + 5'd1;
                  ps_nxt = hrbp_pkg::S_HNAME;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_HNAME, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end
              end
              hrbp_pkg::S_HNAME_TAIL: begin
                if (c == hrbp_pkg::CH_COLON) ps_nxt = hrbp_pkg::S_PRE_VAL;
              end
              hrbp_pkg::S_PRE_VAL, hrbp_pkg::S_HVAL: begin
                if (ps_nxt == hrbp_pkg::S_HVAL && c == hrbp_pkg::CH_CR) begin
                  // Apply the header
                  for (int k = hrbp_pkg::HDR_COUNT - 1; k >= 0; k--) begin
                    if (cand_nxt[k] && hrbp_pkg::hdr_len(3'(k)) == npos_nxt) hk = 3'(k + 1);
                  end
                  if (hk == hrbp_pkg::HK_TYPE) begin
                    tseen_nxt = 1'b1;
                    form_nxt  = (tm_nxt == {1'b0, hrbp_pkg::FORM_LEN});
                  end
                  if (hk == hrbp_pkg::HK_LENGTH)
                    len_nxt = (nneg_nxt && nval_nxt != 20'd0) ? hrbp_pkg::BODY_LIMIT : nval_nxt;
                  ps_nxt = hrbp_pkg::S_HVAL_TAIL;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_HVALUE, 8'd0, hk, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end else if (ps_nxt == hrbp_pkg::S_HVAL && c == hrbp_pkg::CH_LF) begin
                  ps_nxt = hrbp_pkg::S_LINE;
                  res_v[n_v] = mk(hrbp_pkg::KIND_END, hrbp_pkg::PART_HVALUE, 8'd0,
                                  hrbp_pkg::HK_OTHER, 2'd0, ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end else if (ps_nxt == hrbp_pkg::S_HVAL || c != hrbp_pkg::CH_SP) begin
                  // Track the form type match
                  tpos = tm_nxt[5:0];
                  tbad = tm_nxt[6];
                  if (!tbad && tpos < hrbp_pkg::FORM_LEN &&
                      lc == hrbp_pkg::str_at(hrbp_pkg::FORM_TXT, hrbp_pkg::FORM_LEN, tpos))
                    tpos = tpos + 6'd1;
                  else
                    tbad = 1'b1;
                  tm_nxt = {tbad, tpos};
                  // Track the length number
                  more = 1'b1;
                  if (nph_nxt == hrbp_pkg::NP_LEAD) begin
                    if (c == hrbp_pkg::CH_SP || (c >= 8'd9 && c <= 8'd13)) begin
                      more = 1'b0;
                    end else if (c == hrbp_pkg::CH_PLUS || c == hrbp_pkg::CH_MINUS) begin
                      nneg_nxt = (c == hrbp_pkg::CH_MINUS);
                      nph_nxt = hrbp_pkg::NP_FIRST;
                      more = 1'b0;
                    end else begin
                      nph_nxt = hrbp_pkg::NP_FIRST;
                    end
                  end
                  if (more) begin
                    case (nph_nxt)
                      hrbp_pkg::NP_FIRST: begin
                        if (c == "0") begin
                          nval_nxt = 20'd0;  nph_nxt = hrbp_pkg::NP_ZERO;
                        end else if (c >= "1" && c <= "9") begin
                          rdx_nxt = hrbp_pkg::RDX_DEC;  nval_nxt = 20'(c - "0");
                          nph_nxt = hrbp_pkg::NP_DIGITS;
                        end else nph_nxt = hrbp_pkg::NP_STOP;
                      end
                      hrbp_pkg::NP_ZERO: begin
                        if (lc == "x") nph_nxt = hrbp_pkg::NP_HEX1;
                        else if (c >= "0" && c <= "7") begin
                          rdx_nxt = hrbp_pkg::RDX_OCT;  nval_nxt = 20'(c - "0");
                          nph_nxt = hrbp_pkg::NP_DIGITS;
                        end else nph_nxt = hrbp_pkg::NP_STOP;
                      end
                      hrbp_pkg::NP_HEX1: begin
                        if (hrbp_pkg::hex_ok(c)) begin
                          rdx_nxt = hrbp_pkg::RDX_HEX;  nval_nxt = 20'(hrbp_pkg::hex_val(c));
                          nph_nxt = hrbp_pkg::NP_DIGITS;
                        end else nph_nxt = hrbp_pkg::NP_STOP;
                      end
                      hrbp_pkg::NP_DIGITS: begin
                        nd = hrbp_pkg::hex_val(c);
                        case (rdx_nxt)
                          hrbp_pkg::RDX_OCT: nd_ok = c >= "0" && c <= "7";
                          hrbp_pkg::RDX_HEX: nd_ok = hrbp_pkg::hex_ok(c);
                          default:           nd_ok = c >= "0" && c <= "9";
                        endcase
                        if (!nd_ok) nph_nxt = hrbp_pkg::NP_STOP;
                        else begin
                          case (rdx_nxt)
                            hrbp_pkg::RDX_OCT: prod = {2'd0, nval_nxt, 3'd0};
                            hrbp_pkg::RDX_HEX: prod = {1'b0, nval_nxt, 4'd0};
                            default: prod = {2'd0, nval_nxt, 3'd0} + {4'd0, nval_nxt, 1'b0};
                          endcase
                          prod = prod + {21'd0, nd};
                          nval_nxt = (prod > {5'd0, hrbp_pkg::BODY_LIMIT}) ?
                                     hrbp_pkg::BODY_LIMIT : prod[19:0];
                        end
                      end
                      default: ;
                    endcase
                  end
                  ps_nxt = hrbp_pkg::S_HVAL;
                  res_v[n_v] = mk(hrbp_pkg::KIND_DATA, hrbp_pkg::PART_HVALUE, c, 3'd0, 2'd0,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                end
              end
              hrbp_pkg::S_BLANK: begin
                if (c == hrbp_pkg::CH_LF) begin
                  if (len_nxt != 20'd0) begin
                    ps_nxt = (tseen_nxt && form_nxt) ? hrbp_pkg::S_BODY_FORM :
                             hrbp_pkg::S_BODY_RAW;
                    fval_nxt = 1'b0;
                    brx_nxt = 20'd0;
                  end else begin
                    ps_nxt = hrbp_pkg::S_DONE;
                    res_v[n_v] = mk(hrbp_pkg::KIND_DONE, 4'd0, 8'd0, 3'd0, 2'd0,
                                    ps_nxt, ms_nxt, len_nxt, form_nxt);
                    n_v = n_v + 2'd1;
                  end
                end else begin
                  ps_nxt = hrbp_pkg::S_DONE;
                  res_v[n_v] = mk(hrbp_pkg::KIND_ERROR, 4'd0, 8'd0, 3'd0, hrbp_pkg::ERR_NO_LF,
                                  ps_nxt, ms_nxt, len_nxt, form_nxt);
                  n_v = n_v + 2'd1;
                  drop_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        // Flag overflow reached by this byte
        if (!drop_nxt && ps_nxt <= hrbp_pkg::S_BLANK &&
            hdr_nxt >= hrbp_pkg::HDR_CNT_W'(hrbp_pkg::HEADER_LIMIT)) begin
          res_v[n_v] = mk(hrbp_pkg::KIND_ERROR, 4'd0, 8'd0, 3'd0, hrbp_pkg::ERR_OVERFLOW,
                          ps_nxt, ms_nxt, len_nxt, form_nxt);
          n_v = n_v + 2'd1;
          drop_nxt = 1'b1;
        end
      end
    end

    // Mark the final result of the byte
    if (n_v != 2'd0) res_v[n_v - 2'd1].last = 1'b1;
  end

  assign res     = res_v;
  assign res_cnt = n_v;

  // Advance the parse state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= hrbp_pkg::S_METHOD;  esc_ph_r <= 2'd0;  esc_val_r <= 8'd0;
      hdr_r <= '0;  ms_r <= 4'd0;  cand_r <= 7'h7f;  npos_r <= 5'd0;
      tm_r <= 7'd0;  len_r <= 20'd0;  rdx_r <= hrbp_pkg::RDX_NONE;  brx_r <= 20'd0;
      drop_r <= 1'b0;  nph_r <= hrbp_pkg::NP_LEAD;  nneg_r <= 1'b0;  nval_r <= 20'd0;
      tseen_r <= 1'b0;  form_r <= 1'b0;  fval_r <= 1'b0;
    end else if (step) begin
      ps_r <= ps_nxt;  esc_ph_r <= esc_ph_nxt;  esc_val_r <= esc_val_nxt;
      hdr_r <= hdr_nxt;  ms_r <= ms_nxt;  cand_r <= cand_nxt;  npos_r <= npos_nxt;
      tm_r <= tm_nxt;  len_r <= len_nxt;  rdx_r <= rdx_nxt;  brx_r <= brx_nxt;
      drop_r <= drop_nxt;  nph_r <= nph_nxt;  nneg_r <= nneg_nxt;  nval_r <= nval_nxt;
      tseen_r <= tseen_nxt;  form_r <= form_nxt;  fval_r <= fval_nxt;
    end
  end

endmodule

>>> sv/http_request_byte_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Streaming HTTP/1.1 request parser: one received byte in, tagged results out.
// ----------------------------------------------------------------------------
// One byte is taken per request on the input stream and the parse advances in
// that cycle; its zero to three results land in a three-slot output buffer
// that drains one result per cycle while out_tready is high. Under that, with
// at most one result per byte a steady stream runs at one byte per clock; a
// byte with more results holds the input while the buffer empties. The input
// is accepted again in the cycle the last buffered result is taken.
module http_request_byte_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // packet_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [11:8] method_code,
                                  // [14:12] header_kind, [34:15] body_length,
                                  // [35] form_encoded, [37:36] error_code
  output logic [5:0]  out_tuser,  // [1:0] kind, [5:2] part
  output logic        out_tlast   // last
);

  hrbp_pkg::result_t [2:0] res;
  logic [1:0]              res_cnt;
  hrbp_pkg::result_t [2:0] slot_r;
  logic [1:0]              cnt_r;
  logic                    in_acc, out_acc;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_acc     = in_tvalid && in_tready;

  hrbp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .data_byte    (in_tdata),
    .packet_start (in_tuser),
    .res          (res),
    .res_cnt      (res_cnt)
  );

  // Load the results of a new byte, or shift the buffer on each take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= res_cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= res;
    end else if (out_acc) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Drive the head slot
  assign out_tdata = {2'd0, slot_r[0].error_code, slot_r[0].form_encoded,
                      slot_r[0].body_length, slot_r[0].header_kind,
                      slot_r[0].method_code, slot_r[0].out_byte};
  assign out_tuser = {slot_r[0].part, slot_r[0].kind};
  assign out_tlast = slot_r[0].last;

  // Buffer holds while a result stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(cnt_r))
    else $error("result buffer changed under a stall");

  // The final buffered result closes its byte
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> out_tlast)
    else $error("final buffered result not marked last");

  // Earlier results of a byte are not marked last
  a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 || cnt_r == 2'd3) |-> !out_tlast)
    else $error("result marked last ahead of its byte's others");

endmodule
